[hw/rtl/pid_pkg.sv]
// Shared types and constants for the priority interrupt dispatch block.
`timescale 1ns / 1ps

package pid_pkg;

  // Item operation codes
  typedef enum logic [2:0] {
    MODE_STEP      = 3'd0,
    MODE_REQUEST   = 3'd1,
    MODE_WR_FLAGS  = 3'd2,
    MODE_WR_ENABLE = 3'd3,
    MODE_SET_IME   = 3'd4,
    MODE_HALT      = 3'd5
  } mode_t;

  // Result action codes
  typedef enum logic [1:0] {
    ACT_UPDATE   = 2'd0,
    ACT_IDLE     = 2'd1,
    ACT_FETCH    = 2'd2,
    ACT_DISPATCH = 2'd3
  } action_t;

  localparam logic [7:0]  FLAG_RESET   = 8'hE1;
  localparam logic [7:0]  ENABLE_RESET = 8'h00;
  localparam logic [15:0] VECTOR_BASE  = 16'h0040;
  localparam int unsigned NUM_SOURCES  = 5;

endpackage : pid_pkg

[hw/rtl/priority_interrupt_dispatch.sv]
// Fixed-priority interrupt unit: flag/enable/master/halt state and step dispatch.
`timescale 1ns / 1ps

// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+-------------------------------------------
// in_      | input     | in_valid/in_stall  | mode, cur_pc, cur_sp, bit_index, data_byte
// out_     | output    | out_valid/out_stall| action, next_pc, next_sp, push bytes,
//          |           |                    | irq_index, flags/enables/master/halt now
//
// Each transfer on the input lands in an input register; the decode and priority
// encode run combinationally on the held item against the interrupt state, and as
// the item moves on, the state is updated and the result is captured in the output
// register, from which it transfers once the output is not stalled; one item is
// taken every cycle while the input is not stalled.
// Reset (synchronous, rst_n low) loads flags 0xE1, enables 0, master enable
// and halt clear, and empties both registers. A stall on the output holds the
// result; the input register still fills behind it, so the input stalls only
// once both registers hold an item.

module priority_interrupt_dispatch (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_mode,
  input  logic [15:0]       in_cur_pc,
  input  logic [15:0]       in_cur_sp,
  input  logic [2:0]        in_bit_index,
  input  logic [7:0]        in_data_byte,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output pid_pkg::action_t  out_action,
  output logic [15:0]       out_next_pc,
  output logic [15:0]       out_next_sp,
  output logic [7:0]        out_push_high_byte,
  output logic [7:0]        out_push_low_byte,
  output logic [2:0]        out_irq_index,
  output logic [7:0]        out_flags_now,
  output logic [7:0]        out_enables_now,
  output logic              out_master_on,
  output logic              out_is_halted
);

  import pid_pkg::*;

  // Input register
  logic        s1_valid_r;
  logic [2:0]  s1_mode_r;
  logic [15:0] s1_pc_r;
  logic [15:0] s1_sp_r;
  logic [2:0]  s1_bit_r;
  logic [7:0]  s1_data_r;

  // Interrupt state
  logic [7:0]  flag_r,   flag_nxt;
  logic [7:0]  enable_r, enable_nxt;
  logic        ime_r,    ime_nxt;
  logic        halt_r,   halt_nxt;

  // Result register
  logic        out_valid_r;
  action_t     action_r,  action_nxt;
  logic [15:0] npc_r,     npc_nxt;
  logic [15:0] nsp_r,     nsp_nxt;
  logic [7:0]  hi_r,      hi_nxt;
  logic [7:0]  lo_r,      lo_nxt;
  logic [2:0]  idx_r,     idx_nxt;
  logic [7:0]  flags_o_r;
  logic [7:0]  enables_o_r;
  logic        ime_o_r;
  logic        halt_o_r;

  logic        out_ready;
  logic        s1_advance;
  logic        in_take;
  logic [7:0]  pending;
  logic        src_found;
  logic [2:0]  src_idx;

  // The result register takes a new item when empty or when its result transfers.
  assign out_ready  = !out_valid_r || !out_stall;
  assign s1_advance = s1_valid_r && out_ready;
  assign in_stall   = s1_valid_r && !out_ready;
  assign in_take    = in_valid && !in_stall;

  assign pending = flag_r & enable_r;

  // Lowest pending source among the five vectored ones wins.
  always_comb begin
    src_found = 1'b0;
    src_idx   = '0;
    for (int i = NUM_SOURCES - 1; i >= 0; i--) begin
      if (pending[i]) begin
        src_found = 1'b1;
        src_idx   = 3'(i);
      end
    end
  end

  // Decode the held item against the current state.
  always_comb begin
    flag_nxt   = flag_r;
    enable_nxt = enable_r;
    ime_nxt    = ime_r;
    halt_nxt   = halt_r;
    action_nxt = ACT_UPDATE;
    npc_nxt    = s1_pc_r;
    nsp_nxt    = s1_sp_r;
    hi_nxt     = '0;
    lo_nxt     = '0;
    idx_nxt    = '0;
    unique case (s1_mode_r)
      MODE_STEP: begin
        if (halt_r && (pending == 8'h00)) begin
          // halted with nothing pending: report idle, leave state alone
          action_nxt = ACT_IDLE;
        end else begin
          halt_nxt   = 1'b0;
          action_nxt = ACT_FETCH;
          if ((pending != 8'h00) && ime_r) begin
            ime_nxt = 1'b0;
            // pending only in bits 5..7 drops the master enable without a dispatch
            if (src_found) begin
              flag_nxt          = flag_r & ~(8'h01 << src_idx);
              nsp_nxt           = s1_sp_r - 16'd2;
              hi_nxt            = s1_pc_r[15:8];
              lo_nxt            = s1_pc_r[7:0];
              npc_nxt           = VECTOR_BASE + {10'd0, src_idx, 3'b000};
              idx_nxt           = src_idx;
              action_nxt        = ACT_DISPATCH;
            end
          end
        end
      end
      MODE_REQUEST:   flag_nxt   = flag_r | (8'h01 << s1_bit_r);
      MODE_WR_FLAGS:  flag_nxt   = s1_data_r;
      MODE_WR_ENABLE: enable_nxt = s1_data_r;
      MODE_SET_IME:   ime_nxt    = s1_data_r[0];
      MODE_HALT:      halt_nxt   = 1'b1;
      default:        ; // unused codes: plain update, state unchanged
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flag_r      <= FLAG_RESET;
      enable_r    <= ENABLE_RESET;
      ime_r       <= 1'b0;
      halt_r      <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_advance) begin
        s1_valid_r <= 1'b0;
      end
      if (out_ready) begin
        out_valid_r <= s1_valid_r;
      end
      // commit state only as the item moves into the result register
      if (s1_advance) begin
        flag_r   <= flag_nxt;
        enable_r <= enable_nxt;
        ime_r    <= ime_nxt;
        halt_r   <= halt_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_mode_r <= in_mode;
      s1_pc_r   <= in_cur_pc;
      s1_sp_r   <= in_cur_sp;
      s1_bit_r  <= in_bit_index;
      s1_data_r <= in_data_byte;
    end
    if (s1_advance) begin
      action_r    <= action_nxt;
      npc_r       <= npc_nxt;
      nsp_r       <= nsp_nxt;
      hi_r        <= hi_nxt;
      lo_r        <= lo_nxt;
      idx_r       <= idx_nxt;
      flags_o_r   <= flag_nxt;
      enables_o_r <= enable_nxt;
      ime_o_r     <= ime_nxt;
      halt_o_r    <= halt_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_action         = action_r;
  assign out_next_pc        = npc_r;
  assign out_next_sp        = nsp_r;
  assign out_push_high_byte = hi_r;
  assign out_push_low_byte  = lo_r;
  assign out_irq_index      = idx_r;
  assign out_flags_now      = flags_o_r;
  assign out_enables_now    = enables_o_r;
  assign out_master_on      = ime_o_r;
  assign out_is_halted      = halt_o_r;

  // A dispatch always drops the master enable and leaves halt.
  a_dispatch_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (action_r == ACT_DISPATCH)) |-> (!ime_o_r && !halt_o_r))
    else $error("dispatch with master enable or halt still set");

  // The dispatched vector matches the reported source.
  a_dispatch_vector: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (action_r == ACT_DISPATCH)) |->
      ((idx_r < 3'(NUM_SOURCES)) && (npc_r == VECTOR_BASE + {10'd0, idx_r, 3'b000})))
    else $error("dispatch vector does not match source index");

  // Idle is reported only while halted; a fetch always leaves halt.
  a_idle_halted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (action_r == ACT_IDLE)) |-> halt_o_r)
    else $error("idle reported while not halted");

  a_fetch_running: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (action_r == ACT_FETCH)) |-> !halt_o_r)
    else $error("fetch reported while halted");

  // The input backs up only when both registers hold an item.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled with room in the pipeline");

endmodule : priority_interrupt_dispatch

[verif/tb_top.sv]
// Self-checking testbench for the priority interrupt dispatch block.
`timescale 1ns / 1ps

module tb_top;
  import pid_pkg::*;

  // Item codes the package does not name: the block ignores them.
  localparam logic [2:0] MODE_UNUSED6 = 3'd6;
  localparam logic [2:0] MODE_UNUSED7 = 3'd7;

  localparam int MAX_ROWS       = 32;
  localparam int RANDOM_ITEMS   = 1130;
  localparam int IDLE_PCT       = 28;
  localparam int CALM_FIRST     = 500;  // items in [CALM_FIRST, CALM_LAST) run without idling
  localparam int CALM_LAST      = 720;
  localparam int HOLD_AT        = 300;  // transfers in before the long output hold-off
  localparam int HOLD_CYCLES    = 64;
  localparam int DRAIN_CYCLES   = 4;    // two-stage pipe plus margin
  localparam int WATCHDOG_LIMIT = 600;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] pc;
    logic [15:0] sp;
    logic [2:0]  bit_sel;
    logic [7:0]  data;
  } irq_item_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] next_pc;
    logic [15:0] next_sp;
    logic [7:0]  push_hi;
    logic [7:0]  push_lo;
    logic [2:0]  irq;
    logic [7:0]  flags;
    logic [7:0]  enables;
    logic        ime;
    logic        halted;
  } dispatch_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_mode = '0;
  logic [15:0] in_cur_pc = '0;
  logic [15:0] in_cur_sp = '0;
  logic [2:0]  in_bit_index = '0;
  logic [7:0]  in_data_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  action_t     out_action;
  logic [15:0] out_next_pc;
  logic [15:0] out_next_sp;
  logic [7:0]  out_push_high_byte;
  logic [7:0]  out_push_low_byte;
  logic [2:0]  out_irq_index;
  logic [7:0]  out_flags_now;
  logic [7:0]  out_enables_now;
  logic        out_master_on;
  logic        out_is_halted;

  priority_interrupt_dispatch DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_cur_pc          (in_cur_pc),
    .in_cur_sp          (in_cur_sp),
    .in_bit_index       (in_bit_index),
    .in_data_byte       (in_data_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_action         (out_action),
    .out_next_pc        (out_next_pc),
    .out_next_sp        (out_next_sp),
    .out_push_high_byte (out_push_high_byte),
    .out_push_low_byte  (out_push_low_byte),
    .out_irq_index      (out_irq_index),
    .out_flags_now      (out_flags_now),
    .out_enables_now    (out_enables_now),
    .out_master_on      (out_master_on),
    .out_is_halted      (out_is_halted)
  );

  always #4 clk = ~clk;

  // Shadow copy of the interrupt state, advanced once per input transfer.
  logic [7:0] shadow_flags   = FLAG_RESET;
  logic [7:0] shadow_enables = ENABLE_RESET;
  logic       shadow_ime     = 1'b0;
  logic       shadow_halt    = 1'b0;

  dispatch_result_t expected_results[$];

  // Directed table: rows with a pinned result bypass the shadow's answer.
  irq_item_t        row_item[MAX_ROWS];
  bit               row_pinned[MAX_ROWS];
  dispatch_result_t row_want[MAX_ROWS];
  int               n_rows = 0;

  int  items_sent = 0;
  bit  calm = 1'b0;
  int  mismatches = 0;
  int  n_dispatch = 0, n_idle = 0, n_fetch = 0, n_update = 0;
  int  quiet_cycles = 0;

  // Work out the result of one item and advance the shadow state.
  function automatic dispatch_result_t predict_dispatch(irq_item_t it);
    dispatch_result_t r;
    logic [7:0]       pending;
    logic [15:0]      offset;
    bit               found;
    r = '0;
    r.action  = ACT_UPDATE;
    r.next_pc = it.pc;
    r.next_sp = it.sp;
    found     = 1'b0;
    unique case (it.mode)
      MODE_STEP: begin
        pending = shadow_flags & shadow_enables;
        if (shadow_halt && pending == 8'h00) begin
          r.action = ACT_IDLE;
        end else begin
          shadow_halt = 1'b0;
          r.action = ACT_FETCH;
          if (pending != 8'h00 && shadow_ime) begin
            // master enable drops even if only bits 5..7 are pending
            shadow_ime = 1'b0;
            for (int i = 0; i < NUM_SOURCES; i++) begin
              if (!found && pending[i]) begin
                found = 1'b1;
                shadow_flags[i] = 1'b0;
                offset    = 16'(8 * i);
                r.next_pc = VECTOR_BASE + offset;
                r.next_sp = it.sp - 16'd2;
                r.push_hi = it.pc[15:8];
                r.push_lo = it.pc[7:0];
                r.irq     = 3'(i);
                r.action  = ACT_DISPATCH;
              end
            end
          end
        end
      end
      MODE_REQUEST:   shadow_flags[it.bit_sel] = 1'b1;
      MODE_WR_FLAGS:  shadow_flags = it.data;
      MODE_WR_ENABLE: shadow_enables = it.data;
      MODE_SET_IME:   shadow_ime = it.data[0];
      MODE_HALT:      shadow_halt = 1'b1;
      default: ;
    endcase
    r.flags   = shadow_flags;
    r.enables = shadow_enables;
    r.ime     = shadow_ime;
    r.halted  = shadow_halt;
    return r;
  endfunction

  // Mostly interrupt traffic that reaches dispatch: requests, enables, master
  // enable on, steps; a little halt, flag overwrite and unused-code noise.
  function automatic irq_item_t random_item();
    irq_item_t it;
    int        pick;
    it.pc      = 16'($urandom);
    it.sp      = 16'($urandom);
    it.bit_sel = 3'($urandom);
    it.data    = 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 35)      it.mode = MODE_STEP;
    else if (pick < 55) it.mode = MODE_REQUEST;
    else if (pick < 65) it.mode = MODE_WR_ENABLE;
    else if (pick < 73) it.mode = MODE_WR_FLAGS;
    else if (pick < 88) it.mode = MODE_SET_IME;
    else if (pick < 96) it.mode = MODE_HALT;
    else if (pick < 98) it.mode = MODE_UNUSED6;
    else                it.mode = MODE_UNUSED7;
    if (it.mode == MODE_SET_IME)
      it.data[0] = ($urandom_range(99) < 70);
    return it;
  endfunction

  task automatic add_row(input logic [2:0] mode, input logic [15:0] pc, input logic [15:0] sp,
                         input logic [2:0] bit_sel, input logic [7:0] data);
    row_item[n_rows] = '{mode: mode, pc: pc, sp: sp, bit_sel: bit_sel, data: data};
    row_pinned[n_rows] = 1'b0;
    n_rows++;
  endtask

  // Pin the expected result of the row just added.
  task automatic pin_result(input logic [1:0] action, input logic [15:0] npc,
                            input logic [15:0] nsp, input logic [7:0] flags,
                            input logic [7:0] enables, input logic ime, input logic halted);
    dispatch_result_t r;
    r = '0;
    r.action  = action;
    r.next_pc = npc;
    r.next_sp = nsp;
    r.flags   = flags;
    r.enables = enables;
    r.ime     = ime;
    r.halted  = halted;
    row_pinned[n_rows-1] = 1'b1;
    row_want[n_rows-1]   = r;
  endtask

  // Offer one item: idle first at random, then hold it until the transfer.
  task automatic offer_item(input irq_item_t it);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_mode      <= it.mode;
    in_cur_pc    <= it.pc;
    in_cur_sp    <= it.sp;
    in_bit_index <= it.bit_sel;
    in_data_byte <= it.data;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  initial begin : stimulus
    irq_item_t        it;
    dispatch_result_t want;

    // Step out of reset with extreme PC/SP: plain fetch, reset state shown.
    add_row(MODE_STEP, 16'hFFFF, 16'h0000, 3'd0, 8'h00);
    pin_result(ACT_FETCH, 16'hFFFF, 16'h0000, FLAG_RESET, ENABLE_RESET, 1'b0, 1'b0);
    add_row(MODE_HALT, 16'h0000, 16'hFFFF, 3'd7, 8'hFF);
    pin_result(ACT_UPDATE, 16'h0000, 16'hFFFF, FLAG_RESET, ENABLE_RESET, 1'b0, 1'b1);
    // halted with nothing pending: stay halted and report idle
    add_row(MODE_STEP, 16'h1234, 16'h5678, 3'd0, 8'h00);
    pin_result(ACT_IDLE, 16'h1234, 16'h5678, FLAG_RESET, ENABLE_RESET, 1'b0, 1'b1);
    add_row(MODE_WR_ENABLE, 16'h0000, 16'h0000, 3'd0, 8'hFF);
    pin_result(ACT_UPDATE, 16'h0000, 16'h0000, FLAG_RESET, 8'hFF, 1'b0, 1'b1);
    // pending while master enable is off: wake from halt, no dispatch
    add_row(MODE_STEP, 16'h0100, 16'h0200, 3'd0, 8'h00);
    add_row(MODE_SET_IME, 16'h0000, 16'h0000, 3'd0, 8'h01);
    // dispatch source 0 with SP wrapping below zero
    add_row(MODE_STEP, 16'hABCD, 16'h0001, 3'd0, 8'h00);
    // only bits 5..7 pending: master enable drops, nothing dispatched
    add_row(MODE_WR_FLAGS, 16'h0000, 16'h0000, 3'd0, 8'hE0);
    add_row(MODE_SET_IME, 16'h0000, 16'h0000, 3'd0, 8'h01);
    add_row(MODE_STEP, 16'h8000, 16'h8000, 3'd0, 8'h00);
    add_row(MODE_WR_FLAGS, 16'h0000, 16'h0000, 3'd0, 8'h00);
    add_row(MODE_REQUEST, 16'h0000, 16'h0000, 3'd4, 8'h00);
    add_row(MODE_REQUEST, 16'h0000, 16'h0000, 3'd7, 8'h00);
    add_row(MODE_SET_IME, 16'h0000, 16'h0000, 3'd0, 8'hFF);
    // highest vector, SP at zero, all-ones PC bytes pushed
    add_row(MODE_STEP, 16'hFFFF, 16'h0000, 3'd0, 8'h00);
    add_row(MODE_REQUEST, 16'h0000, 16'h0000, 3'd3, 8'h00);
    add_row(MODE_REQUEST, 16'h0000, 16'h0000, 3'd1, 8'h00);
    add_row(MODE_REQUEST, 16'h0000, 16'h0000, 3'd2, 8'h00);
    add_row(MODE_SET_IME, 16'h0000, 16'h0000, 3'd0, 8'h01);
    add_row(MODE_STEP, 16'h7F80, 16'h1000, 3'd0, 8'h00);
    add_row(MODE_SET_IME, 16'h0000, 16'h0000, 3'd0, 8'hFE);
    // unused codes: reported as an update with nothing changed
    add_row(MODE_UNUSED6, 16'h5555, 16'hAAAA, 3'd5, 8'h55);
    add_row(MODE_UNUSED7, 16'hAAAA, 16'h5555, 3'd6, 8'hAA);
    add_row(MODE_REQUEST, 16'h0000, 16'h0000, 3'd0, 8'h00);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int n = 0; n < n_rows + RANDOM_ITEMS; n++) begin
      it = (n < n_rows) ? row_item[n] : random_item();
      calm = (n >= CALM_FIRST && n < CALM_LAST);
      offer_item(it);
      want = predict_dispatch(it);
      if (n < n_rows && row_pinned[n])
        want = row_want[n];
      expected_results.push_back(want);
      items_sent++;
    end
    in_valid <= 1'b0;

    // Drain: wait for every expected transfer, then let the pipe settle.
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d items checked: %0d dispatches, %0d halted idles, %0d fetches, %0d updates",
             items_sent, n_dispatch, n_idle, n_fetch, n_update);
    $display("output held off once for %0d cycles; quiet stretch of items %0d..%0d",
             HOLD_CYCLES, CALM_FIRST, CALM_LAST - 1);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Output stall pattern: random, quiet during the calm stretch, plus one long
  // hold-off so the input register fills and the block stalls its input.
  initial begin : result_pacing
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && items_sent >= HOLD_AT) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Compare each output transfer with the oldest expectation.
  always @(posedge clk) begin : result_check
    dispatch_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: output transfer with nothing expected, action %0d", $time, out_action);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("action", 16'(want.action), 16'(out_action));
        check_field("next_pc", want.next_pc, out_next_pc);
        check_field("next_sp", want.next_sp, out_next_sp);
        check_field("push_high_byte", 16'(want.push_hi), 16'(out_push_high_byte));
        check_field("push_low_byte", 16'(want.push_lo), 16'(out_push_low_byte));
        check_field("irq_index", 16'(want.irq), 16'(out_irq_index));
        check_field("flags_now", 16'(want.flags), 16'(out_flags_now));
        check_field("enables_now", 16'(want.enables), 16'(out_enables_now));
        check_field("master_on", 16'(want.ime), 16'(out_master_on));
        check_field("is_halted", 16'(want.halted), 16'(out_is_halted));
        unique case (want.action)
          ACT_DISPATCH: n_dispatch++;
          ACT_IDLE:     n_idle++;
          ACT_FETCH:    n_fetch++;
          default:      n_update++;
        endcase
      end
    end
  end

  // Watchdog: end the run when no transfer happens on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, no transfer for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, expected_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule
